// ===== hw/rtl/zs_pkg.sv =====
// zs_pkg: shared constants for the z-score standardisation block.
// No dependencies; compiled first.
package zs_pkg;

	localparam int MAX_SAMPLES_DEF = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int Z_W        = 16;  // Q5.11 result width
	localparam int IDX_W      = 6;   // result index field width
	localparam int FRAC_SHIFT = 24;  // (2 * 2^11)^2 scaling of the squared ratio
	localparam int QUOT_W     = 32;  // quotient bits kept by the divider
	localparam int ROOT_W     = QUOT_W / 2;

	localparam logic [Z_W-1:0] Z_POS_MAX = 16'h7FFF;

endpackage

// ===== hw/rtl/zs_if.sv =====
// zs_in_if / zs_out_if: valid/ready channels for samples and results.
// Depends on zs_pkg.
interface zs_in_if
	import zs_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          block_end;

	modport source (output valid, sample, block_end, input ready);
	modport sink   (input valid, sample, block_end, output ready);
endinterface

interface zs_out_if
	import zs_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [Z_W-1:0]   z_value;
	logic        [IDX_W-1:0] sample_index;
	logic                    final_result;
	logic                    flat_input;
	logic                    overflowed;

	modport source (output valid, z_value, sample_index, final_result, flat_input,
		overflowed, input ready);
	modport sink   (input valid, z_value, sample_index, final_result, flat_input,
		overflowed, output ready);
endinterface

// ===== hw/rtl/zscore_standardize_top.sv =====
// zscore_standardize_top: block z-score standardisation, population deviation.
// Depends on zs_pkg and the channel interfaces in zs_if.sv.
//
// Samples are taken one word per cycle while loading into a sample memory (registered
// read) until a word with block_end closes the block; words beyond MAX_SAMPLES are
// dropped and flagged on every result of that block. The block then reads the memory
// back twice. The first pass steps through read, deviation, square and accumulate
// states for each sample and sums the squared deviations d = n*x - S. The second pass
// emits one word per sample in load order: read, multiply and square, then a restoring
// divider (n*d^2*2^24 / sum of squares) and a bit-serial square root. A flat block
// skips divider and root (z forced to zero). The sample channel is ready only while
// loading; no clearing pass is needed after reset.
module zscore_standardize_top
	import zs_pkg::*;
#(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	zs_in_if.sink    samples,
	zs_out_if.source results
);

	localparam int IW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int SW   = SAMPLE_BITS + IW;          // running sum
	localparam int DW   = SW + 1;                    // signed deviation n*x - S
	localparam int MW   = SW;                        // deviation magnitude
	localparam int PW   = 2 * MW;                    // squared magnitude
	localparam int QW   = PW + IW;                   // sum of squares
	localparam int RNW  = PW + CW;                   // n * d^2
	localparam int RW   = RNW + FRAC_SHIFT;          // dividend
	localparam int SRW  = ROOT_W + 2;                // root remainder

	typedef enum logic [3:0] {
		LOAD, Q_RD, Q_D, Q_SQ, Q_ACC, Z_RD, Z_D, Z_SQ, Z_RN, DIV, ROOT, EMIT
	} state_t;

	state_t state_q;

	// sample memory
	logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
	logic signed [SAMPLE_BITS-1:0] rdata_q;

	logic [CW-1:0]        cnt_q;     // loaded samples
	logic signed [SW-1:0] sum_q;
	logic                 ovf_q;
	logic [IW-1:0]        idx_q;
	logic [QW-1:0]        q_q;       // sum of squared deviations

	logic signed [DW-1:0] d_s1;
	logic [PW-1:0]        sq_s2;
	logic                 neg_s2;

	logic [QW-1:0]        rem_q;
	logic [QUOT_W-1:0]    rlo_q;
	logic [QUOT_W-1:0]    quot_q;
	logic [QUOT_W-1:0]    num_q;
	logic [ROOT_W-1:0]    root_q;
	logic [SRW-1:0]       srem_q;
	logic [4:0]           step_q;

	logic signed [Z_W-1:0] z_q;
	logic                  last_q;

	logic                  take;
	logic                  room;
	logic                  idx_last;
	logic signed [DW-1:0]  nx;
	logic [MW-1:0]         mag;
	logic [RNW-1:0]        rn;
	logic [RW-1:0]         dividend;

	// divider step
	logic [QW:0]           div_cat;
	logic                  div_ge;
	logic [QW-1:0]         rem_nxt;
	logic [QUOT_W-1:0]     quot_nxt;

	// root step
	logic [SRW+1:0]        sq_cat;
	logic [SRW+1:0]        sq_trial;
	logic                  sq_ge;
	logic [ROOT_W-1:0]     root_nxt;
	logic [ROOT_W:0]       k_sum;
	logic [ROOT_W-1:0]     k_mag;

	assign take     = samples.valid && samples.ready;
	assign room     = (cnt_q < CW'(MAX_SAMPLES));
	assign idx_last = ((CW'(idx_q) + CW'(1)) == cnt_q);

	// deviation from the registered memory word
	assign nx  = DW'($signed({1'b0, cnt_q})) * DW'(rdata_q);
	assign mag = d_s1[DW-1] ? MW'(-d_s1) : MW'(d_s1);

	// n * d^2, loaded straight into the divider
	assign rn       = RNW'(sq_s2) * RNW'(cnt_q);
	assign dividend = {rn, {FRAC_SHIFT{1'b0}}};

	assign div_cat  = {rem_q, rlo_q[QUOT_W-1]};
	assign div_ge   = (div_cat >= {1'b0, q_q});
	assign rem_nxt  = div_ge ? QW'(div_cat - {1'b0, q_q}) : QW'(div_cat);
	assign quot_nxt = {quot_q[QUOT_W-2:0], div_ge};

	assign sq_cat   = {srem_q, num_q[QUOT_W-1:QUOT_W-2]};
	assign sq_trial = (SRW+2)'({root_q, 2'b01});
	assign sq_ge    = (sq_cat >= sq_trial);
	assign root_nxt = {root_q[ROOT_W-2:0], sq_ge};
	// k = (root + 1) / 2 rounds the half-step odd bound back to a magnitude
	assign k_sum    = {1'b0, root_nxt} + (ROOT_W+1)'(1);
	assign k_mag    = k_sum[ROOT_W:1];

	always_ff @(posedge clk) begin
		if (take && room) begin
			mem[cnt_q[IW-1:0]] <= samples.sample;
		end
		rdata_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LOAD;
			cnt_q   <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
			idx_q   <= '0;
			q_q     <= '0;
			d_s1    <= '0;
			sq_s2   <= '0;
			neg_s2  <= 1'b0;
			rem_q   <= '0;
			rlo_q   <= '0;
			quot_q  <= '0;
			num_q   <= '0;
			root_q  <= '0;
			srem_q  <= '0;
			step_q  <= '0;
			z_q     <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				LOAD: begin
					if (take) begin
						if (room) begin
							cnt_q <= cnt_q + CW'(1);
							sum_q <= sum_q + SW'(samples.sample);
						end else begin
							ovf_q <= 1'b1;
						end
						if (samples.block_end) begin
							idx_q   <= '0;
							q_q     <= '0;
							state_q <= Q_RD;
						end
					end
				end
				Q_RD: state_q <= Q_D;
				Q_D: begin
					d_s1    <= nx - DW'(sum_q);
					state_q <= Q_SQ;
				end
				Q_SQ: begin
					sq_s2   <= PW'(mag) * PW'(mag);
					state_q <= Q_ACC;
				end
				Q_ACC: begin
					q_q <= q_q + QW'(sq_s2);
					if (idx_last) begin
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
					state_q <= idx_last ? Z_RD : Q_RD;
				end
				Z_RD: state_q <= Z_D;
				Z_D: begin
					d_s1   <= nx - DW'(sum_q);
					last_q <= idx_last;
					if (q_q == '0) begin
						z_q     <= '0;
						state_q <= EMIT;
					end else begin
						state_q <= Z_SQ;
					end
				end
				Z_SQ: begin
					sq_s2   <= PW'(mag) * PW'(mag);
					neg_s2  <= d_s1[DW-1];
					state_q <= Z_RN;
				end
				Z_RN: begin
					// divider: dividend loaded on entry, one quotient bit a cycle
					rem_q   <= QW'(dividend[RW-1:QUOT_W]);
					rlo_q   <= dividend[QUOT_W-1:0];
					quot_q  <= '0;
					step_q  <= '0;
					state_q <= DIV;
				end
				DIV: begin
					rem_q  <= rem_nxt;
					rlo_q  <= {rlo_q[QUOT_W-2:0], 1'b0};
					quot_q <= quot_nxt;
					if (step_q == 5'd31) begin
						num_q   <= quot_nxt;
						root_q  <= '0;
						srem_q  <= '0;
						step_q  <= '0;
						state_q <= ROOT;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ROOT: begin
					srem_q <= sq_ge ? SRW'(sq_cat - sq_trial) : SRW'(sq_cat);
					root_q <= root_nxt;
					num_q  <= {num_q[QUOT_W-3:0], 2'b00};
					step_q <= step_q + 5'd1;
					if (step_q == 5'd15) begin
						if (neg_s2) begin
							z_q <= Z_W'(-$signed({1'b0, k_mag}));
						end else if (k_mag > Z_POS_MAX) begin
							z_q <= Z_POS_MAX;
						end else begin
							z_q <= k_mag;
						end
						state_q <= EMIT;
					end
				end
				EMIT: begin
					if (results.ready) begin
						if (last_q) begin
							cnt_q   <= '0;
							sum_q   <= '0;
							ovf_q   <= 1'b0;
							idx_q   <= '0;
							state_q <= LOAD;
						end else begin
							idx_q   <= idx_q + IW'(1);
							state_q <= Z_RD;
						end
					end
				end
				default: state_q <= LOAD;
			endcase
		end
	end

	assign samples.ready        = (state_q == LOAD);
	assign results.valid        = (state_q == EMIT);
	assign results.z_value      = z_q;
	assign results.sample_index = IDX_W'(idx_q);
	assign results.final_result = last_q;
	assign results.flat_input   = (q_q == '0);
	assign results.overflowed   = ovf_q;

endmodule

// ===== hw/rtl/zs_check.sv =====
// zs_check: port-level assertions for zscore_standardize_top, bound to it below.
// Depends on zs_pkg.
module zs_check
	import zs_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic signed [Z_W-1:0] z_value,
	input logic                  final_result,
	input logic                  flat_input
);

	// loading and emitting never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("sample channel ready while a result is shown");

	// the last result of a block reopens the sample channel
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && final_result |=> in_ready)
		else $error("sample channel not reopened after final result");

	// flat block gives zero z-scores
	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flat_input |-> z_value == '0)
		else $error("nonzero z-score on flat block");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(z_value))
		else $error("stalled result changed");

endmodule

bind zscore_standardize_top zs_check u_zs_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (samples.valid),
	.in_ready     (samples.ready),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.z_value      (results.z_value),
	.final_result (results.final_result),
	.flat_input   (results.flat_input)
);

// ===== bench/zs_checker.sv =====
// zs_checker: watches the sample and result channels of the z-score block, predicts
// every result word and compares. Depends on zs_pkg and the channels in zs_if.sv.
`timescale 1ns / 100ps

module zs_checker
	import zs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	zs_in_if     samples,
	zs_out_if    results,
	output int   fails,
	output int   pending,
	output int   words_checked,
	output int   flat_blocks,
	output int   dropped_blocks
);

	typedef struct packed {
		logic signed [Z_W-1:0]   z;
		logic        [IDX_W-1:0] idx;
		logic                    last;
		logic                    flat;
		logic                    ovf;
	} zword_t;

	zword_t    z_expected[$];
	int        held[MAX_SAMPLES_DEF];
	int        held_count;
	longint    held_sum;
	logic      held_dropped;

	// round(2048 * |d| * sqrt(n / sq)), half up, found by bisection on exact squares
	function automatic logic signed [Z_W-1:0] z_of(longint dev, logic [63:0] sq, int n);
		logic [63:0]  mag;
		logic [127:0] rhs;
		logic [127:0] lhs;
		logic [63:0]  t;
		int           lo;
		int           hi;
		int           mid;
		mag = (dev < 0) ? 64'(-dev) : 64'(dev);
		rhs = (128'(mag) * 128'(mag) * 128'(n)) << FRAC_SHIFT;
		lo  = 0;
		hi  = 32768;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			t   = 64'(2 * mid - 1);
			lhs = 128'(t * t) * 128'(sq);
			if (lhs <= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		if (dev < 0)
			return Z_W'(-lo);
		return (lo > 32767) ? Z_POS_MAX : Z_W'(lo);
	endfunction

	task automatic close_block();
		logic [63:0] sq;
		longint      d;
		zword_t      w;
		sq = 0;
		for (int i = 0; i < held_count; i++) begin
			d  = longint'(held_count) * held[i] - held_sum;
			sq += 64'(d * d);
		end
		if (sq == 0)
			flat_blocks++;
		if (held_dropped)
			dropped_blocks++;
		for (int i = 0; i < held_count; i++) begin
			d      = longint'(held_count) * held[i] - held_sum;
			w.z    = (sq == 0) ? '0 : z_of(d, sq, held_count);
			w.idx  = IDX_W'(i);
			w.last = (i + 1 == held_count);
			w.flat = (sq == 0);
			w.ovf  = held_dropped;
			z_expected.push_back(w);
		end
		held_count   = 0;
		held_sum     = 0;
		held_dropped = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		zword_t e;
		zword_t a;
		if (!arst_n) begin
			held_count     = 0;
			held_sum       = 0;
			held_dropped   = 0;
			fails          = 0;
			words_checked  = 0;
			flat_blocks    = 0;
			dropped_blocks = 0;
			z_expected.delete();
		end else begin
			if (results.valid && results.ready) begin
				a = '{results.z_value, results.sample_index, results.final_result,
					results.flat_input, results.overflowed};
				words_checked++;
				if (z_expected.size() == 0) begin
					fails++;
					$display("%0t: unexpected result word %p", $time, a);
				end else begin
					e = z_expected.pop_front();
					if (a !== e) begin
						fails++;
						$display("%0t: mismatch expected %p actual %p", $time, e, a);
					end
				end
			end
			if (samples.valid && samples.ready) begin
				if (held_count < MAX_SAMPLES_DEF) begin
					held[held_count] = int'(samples.sample);
					held_sum += samples.sample;
					held_count++;
				end else
					held_dropped = 1;
				if (samples.block_end)
					close_block();
			end
		end
		pending = z_expected.size();
	end

endmodule

// ===== bench/tb_zscore_standardize_top.sv =====
// tb_zscore_standardize_top: stimulus, clocking and verdict for zscore_standardize_top.
// Depends on zs_pkg, zs_if.sv, the block itself and bench/zs_checker.sv.
`timescale 1ns / 100ps

module tb_zscore_standardize_top;
	import zs_pkg::*;

	logic clk;
	logic arst_n;

	zs_in_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) samples_ch ();
	zs_out_if results_ch ();

	int fails;
	int pending;
	int words_checked;
	int flat_blocks;
	int dropped_blocks;

	int items_sent;
	int blocks_sent;
	int burst_left;
	bit hold_req;      // asks the result side for one long hold-off
	bit hold_taken;
	int hold_left;
	int pat_cnt;
	int pat_mode;

	zscore_standardize_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch)
	);

	zs_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.samples        (samples_ch),
		.results        (results_ch),
		.fails          (fails),
		.pending        (pending),
		.words_checked  (words_checked),
		.flat_blocks    (flat_blocks),
		.dropped_blocks (dropped_blocks)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Result side: a randomly picked mode of always ready, coin toss or mostly ready,
	// plus one long hold-off on request so the block backs up into the sample side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_ch.ready <= 1'b0;
			hold_left  <= 0;
			hold_taken <= 1'b0;
			pat_cnt    <= 0;
			pat_mode   <= 0;
		end else begin
			pat_cnt <= (pat_cnt == 199) ? 0 : pat_cnt + 1;
			if (pat_cnt == 199)
				pat_mode <= $urandom_range(0, 2);
			if (hold_left > 0) begin
				results_ch.ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_req && !hold_taken) begin
				results_ch.ready <= 1'b0;
				hold_left  <= 800;
				hold_taken <= 1'b1;
			end else begin
				case (pat_mode)
					0:       results_ch.ready <= 1'b1;
					1:       results_ch.ready <= $urandom_range(0, 1);
					default: results_ch.ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// one word on the sample side; bursts of random length, random gaps between
	task automatic send_word(logic signed [15:0] s, logic e);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				samples_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		samples_ch.valid     <= 1'b1;
		samples_ch.sample    <= s;
		samples_ch.block_end <= e;
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
		items_sent++;
		if (e)
			blocks_sent++;
	endtask

	task automatic send_block(int vals[$]);
		foreach (vals[i])
			send_word(16'(vals[i]), i == vals.size() - 1);
	endtask

	// random block; style picks spread: full range, narrow, constant or extremes
	task automatic send_random_block(int len);
		int style;
		int base;
		int v;
		style = $urandom_range(0, 5);
		base  = $urandom_range(0, 65535) - 32768;
		for (int i = 0; i < len; i++) begin
			case (style)
				0, 1:    v = $urandom_range(0, 65535) - 32768;
				2:       v = base + $urandom_range(0, 6) - 3;
				3:       v = base;
				4:       v = $urandom_range(0, 1) ? 32767 : -32768;
				default: v = $urandom_range(0, 15) - 8;
			endcase
			send_word(16'(v), i == len - 1);
		end
	endtask

	task automatic drain();
		samples_ch.valid <= 1'b0;
		@(posedge clk);
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int len;
		samples_ch.valid     <= 1'b0;
		samples_ch.sample    <= '0;
		samples_ch.block_end <= 1'b0;
		hold_req   = 1'b0;
		items_sent = 0;
		blocks_sent = 0;
		burst_left = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, one-sample blocks, flat blocks, small spreads
		send_block('{-32768, 32767});
		send_block('{5});
		send_block('{-32768});
		send_block('{7, 7, 7});
		send_block('{-32768, -32768, 32767, 0});
		send_block('{1, -1, 0, 2, -2, 100, -100});
		send_block('{32767, -32768, -32768, -32768, -32768});
		drain();

		// long hold-off on the result side while two blocks queue up behind it
		hold_req = 1'b1;
		send_random_block(6);
		send_random_block(5);
		send_random_block(3);

		// random blocks: mostly short, now and then near, at or past capacity
		while (items_sent < 272) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(60, 70);
			else
				len = $urandom_range(1, 12);
			send_random_block(len);
			if ($urandom_range(0, 4) == 0)
				drain();
		end
		drain();
		repeat (60) @(posedge clk);

		$display("%0d sample words in %0d blocks, %0d result words checked",
			items_sent, blocks_sent, words_checked);
		$display("%0d flat blocks, %0d blocks with dropped samples",
			flat_blocks, dropped_blocks);
		if (fails == 0)
			$display("zscore_standardize_top regression: pass");
		else
			$display("zscore_standardize_top regression: fail");
		$finish;
	end

	initial begin
		#8ms;
		$display("zscore_standardize_top regression: fail");
		$finish;
	end

endmodule
